FILE: rtl/core/rbcm_pkg.sv
// shared types and constants for the residual bin context modeler
// no dependencies
`default_nettype none

package rbcm_pkg;

  localparam int CONTEXT_DEPTH = 512;
  localparam int CTX_AW        = $clog2(CONTEXT_DEPTH);
  localparam int CTX_IDX_W     = 9;

  localparam logic [15:0] PROB_HALF = 16'h8000;

  localparam logic [CTX_IDX_W-1:0] CTX_SIGN_BASE    = 9'd3;
  localparam logic [CTX_IDX_W-1:0] CTX_TREE_BASE    = 9'd6;
  localparam logic [CTX_IDX_W-1:0] CTX_CLASS_STRIDE = 9'd45;
  localparam logic [CTX_IDX_W-1:0] CTX_COMP_STRIDE  = 9'd15;
  localparam logic [2:0]           LEN_CLASS_MAX    = 3'd4;

  localparam logic ACT_TRIPLE = 1'b0;
  localparam logic ACT_UPDATE = 1'b1;

  localparam logic [1:0] LAST_COMP  = 2'd2;
  localparam logic [1:0] LAST_LEVEL = 2'd3;

  localparam logic [CTX_IDX_W-1:0] CTX_Z_NONZERO = 9'd2;
  localparam logic [CTX_IDX_W-1:0] CTX_Z_SIGN    = 9'd5;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_GT0  = 2'd1,
    PH_TREE = 2'd2,
    PH_SIGN = 2'd3
  } phase_t;

  // bin leaving the sequencer
  typedef struct packed {
    logic                 emit;
    logic                 bin_value;
    logic [CTX_IDX_W-1:0] addr;
    logic                 final_bin;
  } res_t;

  // probability write-back into the context store
  typedef struct packed {
    logic                 we;
    logic [CTX_IDX_W-1:0] addr;
    logic [15:0]          data;
  } wr_t;

endpackage

`default_nettype wire

FILE: rtl/core/rbcm_seq.sv
// bin sequencer: phase state machine, context address and bin value
// depends on rbcm_pkg
`default_nettype none

module rbcm_seq (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           fire,
  input  wire logic           action,
  input  wire logic           x_zero,
  input  wire logic [3:0]     x_length,
  input  wire logic           x_sign,
  input  wire logic           y_zero,
  input  wire logic [3:0]     y_length,
  input  wire logic           y_sign,
  input  wire logic           z_zero,
  input  wire logic [3:0]     z_length,
  input  wire logic           z_sign,
  input  wire logic [15:0]    update_prob,
  output rbcm_pkg::res_t      res,
  output rbcm_pkg::wr_t       wr
);

  rbcm_pkg::phase_t phase_r, phase_nxt;
  logic [1:0]  comp_r, comp_nxt;
  logic [2:0]  cls_r, cls_nxt;
  logic [3:0]  node_r, node_nxt;
  logic [1:0]  lvl_r, lvl_nxt;
  logic [17:0] held_r, held_nxt;
  logic        emit;
  logic        adv_comp;
  logic        cur_bit;
  logic [5:0]  cur_slice;
  logic [5:0]  nxt_slice;
  logic [4:0]  cls_sum;
  logic [3:0]  cls_raw;

  function automatic logic [5:0] comp_slice(input logic [17:0] held, input logic [1:0] c);
    logic [5:0] s;
    case (c)
      2'd1:    s = held[11:6];
      2'd2:    s = held[17:12];
      default: s = held[5:0];
    endcase
    return s;
  endfunction

  function automatic logic bin_bit(input rbcm_pkg::phase_t ph, input logic [5:0] s,
                                   input logic [1:0] lvl);
    logic [3:0] len;
    logic       b;
    len = s[4:1];
    case (ph)
      rbcm_pkg::PH_GT0:  b = ~s[5];
      rbcm_pkg::PH_SIGN: b = s[0];
      default:           b = len[2'd3 - lvl];
    endcase
    return b;
  endfunction

  function automatic logic [rbcm_pkg::CTX_IDX_W-1:0] ctx_addr(
    input rbcm_pkg::phase_t ph, input logic [1:0] c, input logic [2:0] cl,
    input logic [3:0] nd);
    logic [rbcm_pkg::CTX_IDX_W-1:0] a;
    case (ph)
      rbcm_pkg::PH_GT0:  a = {7'd0, c};
      rbcm_pkg::PH_SIGN: a = rbcm_pkg::CTX_SIGN_BASE + {7'd0, c};
      default: begin
        a = rbcm_pkg::CTX_TREE_BASE
          + {6'd0, cl} * rbcm_pkg::CTX_CLASS_STRIDE
          + {7'd0, c} * rbcm_pkg::CTX_COMP_STRIDE
          + {5'd0, nd - 4'd1};
      end
    endcase
    return a;
  endfunction

  assign cur_slice = comp_slice(held_r, comp_r);
  assign cur_bit   = bin_bit(phase_r, cur_slice, lvl_r);
  assign cls_sum   = {1'b0, held_r[4:1]} + 5'd1;
  assign cls_raw   = cls_sum[4:1];

  // next state
  always_comb begin
    phase_nxt = phase_r;
    comp_nxt  = comp_r;
    cls_nxt   = cls_r;
    node_nxt  = node_r;
    lvl_nxt   = lvl_r;
    held_nxt  = held_r;
    emit      = 1'b0;
    adv_comp  = 1'b0;
    wr.we     = 1'b0;
    wr.addr   = ctx_addr(phase_r, comp_r, cls_r, node_r);
    wr.data   = update_prob;
    if (fire) begin
      if (action == rbcm_pkg::ACT_TRIPLE) begin
        if (phase_r == rbcm_pkg::PH_IDLE) begin
          held_nxt  = {z_zero, z_length, z_sign, y_zero, y_length, y_sign,
                       x_zero, x_length, x_sign};
          comp_nxt  = 2'd0;
          cls_nxt   = 3'd0;
          node_nxt  = 4'd1;
          lvl_nxt   = 2'd0;
          phase_nxt = rbcm_pkg::PH_GT0;
          emit      = 1'b1;
        end
      end else if (phase_r != rbcm_pkg::PH_IDLE) begin
        wr.we = 1'b1;
        emit  = 1'b1;
        case (phase_r)
          rbcm_pkg::PH_GT0: begin
            if (cur_slice[5]) begin
              adv_comp = 1'b1;
            end else begin
              node_nxt  = 4'd1;
              lvl_nxt   = 2'd0;
              phase_nxt = rbcm_pkg::PH_TREE;
            end
          end
          rbcm_pkg::PH_TREE: begin
            if (lvl_r == rbcm_pkg::LAST_LEVEL) begin
              node_nxt  = 4'd1;
              lvl_nxt   = 2'd0;
              phase_nxt = rbcm_pkg::PH_SIGN;
            end else begin
              node_nxt = {node_r[2:0], cur_bit};
              lvl_nxt  = lvl_r + 2'd1;
            end
          end
          default: adv_comp = 1'b1;
        endcase
        if (adv_comp) begin
          if (comp_r == 2'd0) begin
            cls_nxt = (cls_raw > {1'b0, rbcm_pkg::LEN_CLASS_MAX}) ?
                      rbcm_pkg::LEN_CLASS_MAX : cls_raw[2:0];
          end
          if (comp_r == rbcm_pkg::LAST_COMP) begin
            comp_nxt  = 2'd0;
            phase_nxt = rbcm_pkg::PH_IDLE;
            emit      = 1'b0;
          end else begin
            comp_nxt  = comp_r + 2'd1;
            phase_nxt = rbcm_pkg::PH_GT0;
          end
        end
      end
    end
  end

  // bin for the state being entered
  assign nxt_slice = comp_slice(held_nxt, comp_nxt);

  always_comb begin
    res.emit      = emit;
    res.bin_value = bin_bit(phase_nxt, nxt_slice, lvl_nxt);
    res.addr      = ctx_addr(phase_nxt, comp_nxt, cls_nxt, node_nxt);
    res.final_bin = (comp_nxt == rbcm_pkg::LAST_COMP) &&
                    ((phase_nxt == rbcm_pkg::PH_SIGN) ||
                     ((phase_nxt == rbcm_pkg::PH_GT0) && nxt_slice[5]));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= rbcm_pkg::PH_IDLE;
      comp_r  <= 2'd0;
      cls_r   <= 3'd0;
      node_r  <= 4'd1;
      lvl_r   <= 2'd0;
      held_r  <= 18'd0;
    end else begin
      phase_r <= phase_nxt;
      comp_r  <= comp_nxt;
      cls_r   <= cls_nxt;
      node_r  <= node_nxt;
      lvl_r   <= lvl_nxt;
      held_r  <= held_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/rbcm_ctx_store.sv
// context probability store: one write and one registered read per cycle,
// cleared to half by a reset sweep that blocks writes; depends on rbcm_pkg
`default_nettype none

module rbcm_ctx_store (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire rbcm_pkg::wr_t                      wr,
  input  wire logic                               rd_en,
  input  wire logic [rbcm_pkg::CTX_IDX_W-1:0]     rd_addr,
  output logic [15:0]                             rd_data,
  output logic                                    clr_busy
);

  logic [15:0]                 mem [rbcm_pkg::CONTEXT_DEPTH];
  logic [rbcm_pkg::CTX_AW-1:0] clr_cnt_r, clr_cnt_nxt;
  logic                        clr_busy_r, clr_busy_nxt;
  logic [15:0]                 rd_data_r;

  always_comb begin
    clr_cnt_nxt  = clr_cnt_r;
    clr_busy_nxt = clr_busy_r;
    if (clr_busy_r) begin
      clr_cnt_nxt = clr_cnt_r + 1'b1;
      if (clr_cnt_r == rbcm_pkg::CTX_AW'(rbcm_pkg::CONTEXT_DEPTH - 1)) begin
        clr_busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r  <= '0;
      clr_busy_r <= 1'b1;
    end else begin
      clr_cnt_r  <= clr_cnt_nxt;
      clr_busy_r <= clr_busy_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (clr_busy_r) begin
      mem[clr_cnt_r] <= rbcm_pkg::PROB_HALF;
    end else if (wr.we) begin
      mem[rbcm_pkg::CTX_AW'(wr.addr)] <= wr.data;
    end
  end

  // write-through when both ports hit the same entry
  always_ff @(posedge clk) begin
    if (rd_en) begin
      if (wr.we && (wr.addr == rd_addr)) begin
        rd_data_r <= wr.data;
      end else begin
        rd_data_r <= mem[rbcm_pkg::CTX_AW'(rd_addr)];
      end
    end
  end

  assign rd_data  = rd_data_r;
  assign clr_busy = clr_busy_r;

endmodule

`default_nettype wire

FILE: rtl/core/residual_bin_context_modeler_top.sv
// top level of the residual bin context modeler: handshakes and result register
// depends on rbcm_pkg, rbcm_seq, rbcm_ctx_store
`default_nettype none

// One input item is taken per clock cycle whenever the clearing sweep is over and
// the result register is empty or its bin leaves in the same cycle; an item that
// yields a bin shows it at the outputs in the cycle after its transfer, with the
// probability read from the single-port-write, single-port-read context memory
// in that cycle. After reset the context memory is swept to 0x8000 one entry a
// cycle, so in_stall stays high until all CONTEXT_DEPTH (512) entries are set.
module residual_bin_context_modeler_top (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        in_action,
  input  wire logic        in_x_zero,
  input  wire logic [3:0]  in_x_length,
  input  wire logic        in_x_sign,
  input  wire logic        in_y_zero,
  input  wire logic [3:0]  in_y_length,
  input  wire logic        in_y_sign,
  input  wire logic        in_z_zero,
  input  wire logic [3:0]  in_z_length,
  input  wire logic        in_z_sign,
  input  wire logic [15:0] in_update_prob,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             out_bin_value,
  output logic [15:0]      out_bin_probability,
  output logic [8:0]       out_context_index,
  output logic             out_final_bin
);

  rbcm_pkg::res_t res;
  rbcm_pkg::wr_t  wr;
  logic           fire;
  logic           clr_busy;
  logic [15:0]    rd_data;
  logic           out_valid_r, out_valid_nxt;
  logic           bin_value_r;
  logic [8:0]     ctx_idx_r;
  logic           final_bin_r;

  assign in_stall = clr_busy || (out_valid_r && out_stall);
  assign fire     = in_valid && !in_stall;

  rbcm_seq u_seq (
    .clk         (clk),
    .rst_n       (rst_n),
    .fire        (fire),
    .action      (in_action),
    .x_zero      (in_x_zero),
    .x_length    (in_x_length),
    .x_sign      (in_x_sign),
    .y_zero      (in_y_zero),
    .y_length    (in_y_length),
    .y_sign      (in_y_sign),
    .z_zero      (in_z_zero),
    .z_length    (in_z_length),
    .z_sign      (in_z_sign),
    .update_prob (in_update_prob),
    .res         (res),
    .wr          (wr)
  );

  rbcm_ctx_store u_store (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr       (wr),
    .rd_en    (res.emit),
    .rd_addr  (res.addr),
    .rd_data  (rd_data),
    .clr_busy (clr_busy)
  );

  assign out_valid_nxt = res.emit || (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res.emit) begin
      bin_value_r <= res.bin_value;
      ctx_idx_r   <= res.addr;
      final_bin_r <= res.final_bin;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_bin_value       = bin_value_r;
  assign out_bin_probability = rd_data;
  assign out_context_index   = ctx_idx_r;
  assign out_final_bin       = final_bin_r;

  // last bin is always z's sign or z's nonzero flag
  a_final_ctx: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_final_bin) |->
      (out_context_index == rbcm_pkg::CTX_Z_SIGN ||
       out_context_index == rbcm_pkg::CTX_Z_NONZERO))
    else $error("final bin on unexpected context");

  // write-back and next read never share an entry
  a_rw_apart: assert property (@(posedge clk) disable iff (!rst_n)
    (wr.we && res.emit) |-> (wr.addr != res.addr))
    else $error("write-back and read hit the same context");

  // a new bin needs an input transfer in the cycle before
  a_bin_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(fire))
    else $error("bin appeared without an input transfer");

  // nothing is taken during the clearing sweep
  a_no_fire_clr: assert property (@(posedge clk) disable iff (!rst_n)
    clr_busy |-> !res.emit && !wr.we)
    else $error("context store accessed during clearing");

endmodule

`default_nettype wire
